// ===== hdl/ped_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, character codes and hex helpers for the percent-escape
// decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    localparam int unsigned MAX_RESULTS = 3;

    // Escape phase; the unused code behaves as idle
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // Up to three result bytes caused by one input byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [1:0]                  count;
        logic                        last;
    } bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_ZERO)  && (c <= CH_NINE))  ||
               ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
               ((c >= CH_UP_A)  && (c <= CH_UP_F));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            d = c - CH_ZERO;
        else if ((c >= CH_LOW_A) && (c <= CH_LOW_F))
            d = c - CH_LOW_A + {4'd0, HEX_TEN};
        else if ((c >= CH_UP_A) && (c <= CH_UP_F))
            d = c - CH_UP_A + {4'd0, HEX_TEN};
        return d[3:0];
    endfunction

endpackage

// ===== hdl/ped_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_if
// Valid/ready channels for raw input bytes and decoded result bytes.
// ----------------------------------------------------------------------------
interface ped_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ped_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;

    modport source (output valid, output out_byte, output run_end, output message_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_end, input message_end,
                    output ready);
endinterface

// ===== hdl/ped_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_front
// Accepts raw bytes, tracks the escape phase and builds the bundle of
// result bytes that each input byte causes.
// ----------------------------------------------------------------------------
module ped_front
    import ped_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ped_in_if.sink  in_ch,
    input  logic    q_full,
    output logic    q_push,
    output bundle_t q_data
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic [7:0] c;
    logic       last;
    logic       c_hex;
    logic       accept;
    logic       plain_emit;
    logic [7:0] plain_val;
    bundle_t    bundle;

    assign c      = in_ch.in_byte;
    assign last   = in_ch.last_byte;
    assign c_hex  = is_hex(c);
    assign in_ch.ready = !q_full;
    assign accept = in_ch.valid && in_ch.ready;

    // Classify the byte as handled from the idle phase
    always_comb
    begin
        plain_emit = 1'b1;
        plain_val  = c;
        if (c == CH_PLUS)
            plain_val = CH_SPACE;
        else if ((c == CH_PERCENT) && !last)
            plain_emit = 1'b0;
    end

    // Next escape phase and held digit; a percent that is handled as a plain
    // byte and is not last opens a new escape
    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (c_hex && !last)
                begin
                    held_next  = c;
                    phase_next = PH_DIGIT;
                end
                else if (!plain_emit)
                begin
                    phase_next = PH_PCT;
                end
            end
            PH_DIGIT:
            begin
                held_next = 8'd0;
                if (!plain_emit)
                    phase_next = PH_PCT;
            end
            default:
            begin
                if (!plain_emit)
                    phase_next = PH_PCT;
            end
        endcase
        if (last)
        begin
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    // Result bundle for this byte
    always_comb
    begin
        bundle      = '0;
        bundle.last = last;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (!(c_hex && !last))
                begin
                    bundle.data[0] = CH_PERCENT;
                    if (c_hex)
                    begin
                        bundle.data[1] = c;
                        bundle.count   = 2'd2;
                    end
                    else
                    begin
                        bundle.data[1] = plain_val;
                        bundle.count   = plain_emit ? 2'd2 : 2'd1;
                    end
                end
            end
            PH_DIGIT:
            begin
                if (c_hex)
                begin
                    bundle.data[0] = {hex_value(held_reg), hex_value(c)};
                    bundle.count   = 2'd1;
                end
                else
                begin
                    bundle.data[0] = CH_PERCENT;
                    bundle.data[1] = held_reg;
                    bundle.data[2] = plain_val;
                    bundle.count   = plain_emit ? 2'd3 : 2'd2;
                end
            end
            default:
            begin
                bundle.data[0] = plain_val;
                bundle.count   = plain_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    // Queue only bytes that cause results
    assign q_push = accept && (bundle.count != 2'd0);
    assign q_data = bundle;

    // Advance the escape state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hdl/ped_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_queue
// Small FIFO of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module ped_queue
    import ped_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    empty,
    output bundle_t head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    bundle_t       mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store bundles
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hdl/ped_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_back
// Serializes queued bundles into single result bytes through an output
// register, one byte per cycle while bundles are queued and the output is ready.
// ----------------------------------------------------------------------------
module ped_back
    import ped_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  bundle_t  q_head,
    output logic     q_pop,
    ped_out_if.source out_ch
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       run_end_reg;
    logic       msg_end_reg;
    logic       load;
    logic       fin;
    logic [7:0] sel_byte;

    assign load = (!valid_reg || out_ch.ready) && !q_empty;
    assign fin  = (idx_reg == (q_head.count - 2'd1));

    // Pick the current byte of the head bundle
    always_comb
    begin
        case (idx_reg)
            2'd1:    sel_byte = q_head.data[1];
            2'd2:    sel_byte = q_head.data[2];
            default: sel_byte = q_head.data[0];
        endcase
    end

    assign q_pop = load && fin;

    // Advance the byte index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = fin ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= sel_byte;
            run_end_reg <= fin;
            msg_end_reg <= fin && q_head.last;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.run_end     = run_end_reg;
    assign out_ch.message_end = msg_end_reg;

endmodule

// ===== hdl/percent_escape_decoder_core.sv =====
`timescale 1ns / 1ps
// Each result byte passes through the bundle queue and then the output
// register of the back part. The front takes one input byte per cycle
// while the bundle queue is not full; the back part emits one result byte
// per cycle while the output is ready, so a byte causing two or three
// results holds it for each of them while the queue absorbs the input side.
// Reset: clears the escape phase, held digit, queue and output valid.
// ----------------------------------------------------------------------------
// percent_escape_decoder_core
// Streaming URL percent decoder: front classifier, bundle queue and
// serializing back part.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core
    import ped_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    ped_in_if.sink    in_ch,
    ped_out_if.source out_ch
);

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    bundle_t q_wdata;
    bundle_t q_head;

    // Classify input bytes
    ped_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // Decouple front and back
    ped_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Emit result bytes
    ped_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// ===== test/tb_percent_escape_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_percent_escape_decoder_core
// Self-checking bench for the streaming percent decoder. A short table of
// directed bytes covers plus, hex edges in both cases, broken escapes and
// messages that end inside an escape. After that, random messages are built
// mostly from well-formed escapes with random content, mixed with noise.
// Every accepted input is run through a local decoder model. Each result
// transfer is checked field by field against the oldest predicted byte.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_percent_escape_decoder_core;
    import ped_pkg::*;

    localparam int DIR_ROWS     = 29;
    localparam int RAND_ITEMS   = 300;
    localparam int DRAIN_CYCLES = 10;

    // One directed row; when typed is set, count/b0..b2 give the expected bytes
    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       typed;
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } dir_row_t;

    // One expected result byte with its framing flags
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       message_end;
    } decoded_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // plain extremes and plus
        '{8'h00,      1'b0, 1'b1, 2'd1, 8'h00,      8'h00,      8'h00},
        '{8'hFF,      1'b0, 1'b1, 2'd1, 8'hFF,      8'h00,      8'h00},
        '{CH_PLUS,    1'b0, 1'b1, 2'd1, CH_SPACE,   8'h00,      8'h00},
        // hex digit edges in both cases
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_ZERO,    1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_LOW_F,   1'b0, 1'b1, 2'd1, 8'h0F,      8'h00,      8'h00},
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_NINE,    1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_UP_A,    1'b0, 1'b1, 2'd1, 8'h9A,      8'h00,      8'h00},
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_UP_F,    1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_LOW_A,   1'b0, 1'b1, 2'd1, 8'hFA,      8'h00,      8'h00},
        // broken right after the percent; second percent restarts the escape
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_PERCENT, 1'b0, 1'b1, 2'd1, CH_PERCENT, 8'h00,      8'h00},
        '{8'h47,      1'b0, 1'b1, 2'd2, CH_PERCENT, 8'h47,      8'h00},
        // broken after one hex digit
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_LOW_A,   1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{8'h7A,      1'b0, 1'b1, 2'd3, CH_PERCENT, CH_LOW_A,   8'h7A},
        // broken by a plus on the final byte
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_NINE,    1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_PLUS,    1'b1, 1'b1, 2'd3, CH_PERCENT, CH_NINE,    CH_SPACE},
        // message ends inside an escape
        '{CH_PERCENT, 1'b1, 1'b1, 2'd1, CH_PERCENT, 8'h00,      8'h00},
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{8'h80,      1'b1, 1'b1, 2'd2, CH_PERCENT, 8'h80,      8'h00},
        '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,      8'h00},
        '{8'h35,      1'b1, 1'b1, 2'd2, CH_PERCENT, 8'h35,      8'h00},
        '{CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,      8'h00},
        '{8'h37,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,      8'h00},
        '{CH_PERCENT, 1'b1, 1'b0, 2'd0, 8'h00,      8'h00,      8'h00}
    };

    logic clk;
    logic rst_n;

    ped_in_if  in_ch ();
    ped_out_if out_ch ();

    percent_escape_decoder_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Decoder model state and the bytes produced by the current step
    phase_t     esc_phase;
    logic [7:0] held_char;
    logic [7:0] step_bytes [0:2];
    int         step_count;
    decoded_t   decoded_q [$];

    int   errors;
    int   items_sent;
    int   messages_sent;
    int   results_seen;
    int   escapes_decoded;
    logic src_calm;
    logic sink_calm;

    // Clock: 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic hex_char(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_F));
    endfunction

    // Digits carry their value in the low nibble; letters map a..f by low bits
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            v = c & 8'h0F;
        else if (hex_char(c))
            v = (c & 8'h07) + 8'd9;
        else
            v = 8'd0;
        return v[3:0];
    endfunction

    function automatic void emit(input logic [7:0] b);
        step_bytes[step_count] = b;
        step_count++;
    endfunction

    // Handle a byte with no escape pending
    function automatic void take_plain(input logic [7:0] c, input logic last);
        if (c == CH_PLUS)
            emit(CH_SPACE);
        else if (c == CH_PERCENT)
        begin
            if (last)
                emit(CH_PERCENT);
            else
                esc_phase = PH_PCT;
        end
        else
            emit(c);
    endfunction

    // Advance the decoder model by one raw byte
    function automatic void decode_step(input logic [7:0] c, input logic last);
        phase_t ph;
        ph         = esc_phase;
        step_count = 0;
        esc_phase  = PH_IDLE;
        case (ph)
            PH_PCT:
            begin
                if (hex_char(c) && !last)
                begin
                    held_char = c;
                    esc_phase = PH_DIGIT;
                end
                else
                begin
                    emit(CH_PERCENT);
                    if (hex_char(c))
                        emit(c);
                    else
                        take_plain(c, last);
                end
            end
            PH_DIGIT:
            begin
                if (hex_char(c))
                begin
                    emit({hex_nibble(held_char), hex_nibble(c)});
                    escapes_decoded++;
                end
                else
                begin
                    emit(CH_PERCENT);
                    emit(held_char);
                    take_plain(c, last);
                end
                held_char = 8'h00;
            end
            default:
                take_plain(c, last);
        endcase
        if (last)
        begin
            esc_phase = PH_IDLE;
            held_char = 8'h00;
        end
    endfunction

    // Queue the bytes of the current step with their framing flags
    function automatic void queue_step(input logic last);
        decoded_t d;
        for (int k = 0; k < step_count; k++)
        begin
            d.data        = step_bytes[k];
            d.run_end     = (k == step_count - 1);
            d.message_end = (k == step_count - 1) && last;
            decoded_q.push_back(d);
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(12, 30);
    endfunction

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return CH_ZERO + 8'(r);
        if (r < 16)
            return CH_LOW_A + 8'(r - 10);
        return CH_UP_A + 8'(r - 16);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    // Drive one byte at the falling edge and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_calm ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        items_sent++;
        if (last)
            messages_sent++;
    endtask

    // Drop valid and hold off until every predicted byte has come out
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls with calm stretches
    initial
    begin
        int stall_left;
        int mode_left;
        stall_left   = 0;
        mode_left    = 0;
        sink_calm    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                sink_calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_calm)
                out_ch.ready <= 1'b1;
            else
            begin
                stall_left = idle_len();
                out_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1))
        begin
            results_seen++;
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
            else
            begin
                want = decoded_q.pop_front();
                if (out_ch.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_ch.out_byte, want.data));
                if (out_ch.run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %b, want %b on byte %02h",
                                              out_ch.run_end, want.run_end, want.data));
                if (out_ch.message_end !== want.message_end)
                    report_mismatch($sformatf("message_end %b, want %b on byte %02h",
                                              out_ch.message_end, want.message_end,
                                              want.data));
            end
        end
    end

    // Stimulus
    initial
    begin
        dir_row_t   row;
        logic [7:0] msg_q [$];
        int         ntok;
        int         r;

        errors          = 0;
        items_sent      = 0;
        messages_sent   = 0;
        results_seen    = 0;
        escapes_decoded = 0;
        src_calm        = 1'b0;
        esc_phase       = PH_IDLE;
        held_char       = 8'h00;
        step_count      = 0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.last_byte = 1'b0;
        rst_n           = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            send_byte(row.raw, row.last);
            decode_step(row.raw, row.last);
            if (row.typed)
            begin
                step_count    = row.count;
                step_bytes[0] = row.b0;
                step_bytes[1] = row.b1;
                step_bytes[2] = row.b2;
            end
            queue_step(row.last);
        end
        wait_drained();

        // Random messages, mostly well-formed escapes with random content
        while (items_sent < DIR_ROWS + RAND_ITEMS)
        begin
            msg_q = {};
            ntok  = $urandom_range(1, 8);
            repeat (ntok)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    msg_q.push_back(CH_PERCENT);
                    msg_q.push_back(rand_hex());
                    msg_q.push_back(rand_hex());
                end
                else if (r < 60)
                    msg_q.push_back(8'($urandom_range(0, 255)));
                else if (r < 70)
                    msg_q.push_back(CH_PLUS);
                else if (r < 85)
                begin
                    msg_q.push_back(CH_PERCENT);
                    msg_q.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    msg_q.push_back(CH_PERCENT);
                    msg_q.push_back(rand_hex());
                    msg_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            // Sometimes end the message inside an escape
            r = $urandom_range(0, 99);
            if (r < 12)
                msg_q.push_back(CH_PERCENT);
            else if (r < 22)
            begin
                msg_q.push_back(CH_PERCENT);
                msg_q.push_back(rand_hex());
            end

            src_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < msg_q.size(); k++)
            begin
                send_byte(msg_q[k], k == msg_q.size() - 1);
                decode_step(msg_q[k], k == msg_q.size() - 1);
                queue_step(k == msg_q.size() - 1);
            end
            if (messages_sent % 8 == 0)
                wait_drained();
        end

        // Let the last results out, then watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages, %0d escapes decoded.",
                 items_sent, messages_sent, escapes_decoded);
        $display("Checked %0d result bytes with random stalls on both sides.", results_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ped_pkg.sv
hdl/ped_if.sv
hdl/ped_front.sv
hdl/ped_queue.sv
hdl/ped_back.sv
hdl/percent_escape_decoder_core.sv
test/tb_percent_escape_decoder_core.sv
